[src/plr_pkg.sv]
// shared types and constants of the polyline rasterizer
`default_nettype none

package plr_pkg;

    localparam int POS_W       = 15;  // vertex coordinate width
    localparam int DELTA_W     = 16;  // signed vertex-to-vertex difference
    localparam int CELL_W      = 5;   // cell index width on the output bus
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    // one segment handed from the front end to the walker
    typedef struct packed {
        logic [POS_W-1:0] ax;
        logic [POS_W-1:0] ay;
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
    } seg_t;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul;   // register a new product
        logic load;  // accumulator takes the product
        logic sub;   // accumulator subtracts the product
    } mac_ctrl_t;

endpackage

`default_nettype wire

[src/polyline_four_connected_rasterizer.sv]
// top level of the four-connected polyline rasterizer
//
// Vertices arrive one request at a time on the slave stream; each is rounded to
// the nearest grid cell and, unless it opens a curve, the segment from the
// previous vertex is walked and its cells leave on the master stream in order,
// with tlast on the last cell of each segment. A vertex that opens a curve (or
// the first one after reset) is taken and emits nothing. The single shared
// multiplier evaluates four products for the corner cell of every diagonal
// step, one after another. s_tready is low while a segment is being walked;
// the last cell may still sit in the output register while the next vertex
// is taken.
`default_nettype none

module polyline_four_connected_rasterizer #(
    parameter int GRID_SIZE = 32,
    parameter int FRAC_BITS = 10
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire [plr_pkg::IN_TDATA_W-1:0]       s_tdata,   // pos_x, pos_y
    input  wire                                 s_tuser,   // curve_start
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [plr_pkg::OUT_TDATA_W-1:0]     m_tdata,   // cell_x, cell_y
    output logic                                m_tlast    // segment_end
);

    localparam int POS_W = plr_pkg::POS_W;

    logic [POS_W-1:0] prev_x_reg, prev_y_reg;
    logic             have_prev_reg;
    logic [POS_W-1:0] pos_x, pos_y;
    logic             accept;
    logic             walk_start;
    logic             busy;
    plr_pkg::seg_t    seg;

    assign pos_x      = s_tdata[POS_W-1:0];
    assign pos_y      = s_tdata[2*POS_W-1:POS_W];
    assign s_tready   = !busy;
    assign accept     = s_tvalid && s_tready;
    assign walk_start = accept && !s_tuser && have_prev_reg;

    always_comb
    begin
        seg.ax = prev_x_reg;
        seg.ay = prev_y_reg;
        seg.cx = pos_x;
        seg.cy = pos_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (accept)
        begin
            prev_x_reg    <= pos_x;
            prev_y_reg    <= pos_y;
            have_prev_reg <= 1'b1;
        end
    end

    plr_walk #(
        .GRID_SIZE (GRID_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (walk_start),
        .seg      (seg),
        .busy     (busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[src/plr_mac.sv]
// shared signed multiply-accumulate unit for the cross products
`default_nettype none

module plr_mac #(
    parameter int OB_W = 23
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  plr_pkg::mac_ctrl_t                ctrl,
    input  wire signed [plr_pkg::DELTA_W-1:0] op_a,
    input  wire signed [OB_W-1:0]             op_b,
    output logic [plr_pkg::DELTA_W+OB_W:0]    mag
);

    localparam int PW = plr_pkg::DELTA_W + OB_W;
    localparam int AW = PW + 1;

    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] prod_ext;

    assign prod_ext = AW'(prod_reg);
    assign mag      = acc_reg[AW-1] ? unsigned'(-acc_reg) : unsigned'(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (ctrl.mul)
            begin
                prod_reg <= PW'(op_a) * PW'(op_b);
            end
            if (ctrl.load)
            begin
                acc_reg <= prod_ext;
            end
            else if (ctrl.sub)
            begin
                acc_reg <= acc_reg - prod_ext;
            end
        end
    end

endmodule

`default_nettype wire

[src/plr_walk.sv]
// segment walker: rounding, bresenham stepping and corner cell choice
`default_nettype none

module plr_walk #(
    parameter int GRID_SIZE = 32,
    parameter int FRAC_BITS = 10
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    input  plr_pkg::seg_t                        seg,
    output logic                                 busy,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [plr_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast
);

    localparam int POS_W = plr_pkg::POS_W;
    localparam int FW    = plr_pkg::DELTA_W;
    localparam int OW    = plr_pkg::CELL_W;
    localparam int CW    = $clog2(GRID_SIZE);
    localparam int EW    = CW + 2;
    localparam int SW    = POS_W + 1;
    localparam int NW    = CW + FRAC_BITS;
    localparam int DW    = ((NW > POS_W) ? NW : POS_W) + 1;
    localparam int MW    = FW + DW + 1;
    localparam int HALF  = 1 << (FRAC_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ROUND, S_PREP, S_STEP,
        S_MA0, S_MA1, S_MA2, S_MB0, S_MB1, S_MB2, S_DIAG
    } state_t;

    state_t                state_reg;
    plr_pkg::seg_t         seg_reg;
    logic signed [FW-1:0]  fdx_reg, fdy_reg;
    logic [CW-1:0]         x_reg, y_reg, x2_reg, y2_reg;
    logic [CW-1:0]         ca_x_reg, ca_y_reg;
    logic                  xmaj_reg, sxn_reg, syn_reg;
    logic signed [EW-1:0]  e_reg, inc1_reg, inc2_reg;
    logic [CW-1:0]         cnt_reg;
    logic [MW-1:0]         a_mag_reg;
    logic                  ovalid_reg, olast_reg;
    logic [CW-1:0]         ox_reg, oy_reg;

    // setup helpers
    logic signed [CW:0]    ddx, ddy;
    logic [CW-1:0]         adx, ady, dmaj, dmin;
    logic                  xmaj;
    logic signed [EW-1:0]  two_min, two_maj, e0, inc2;

    // step helpers
    logic                  out_free;
    logic                  emit;
    logic [CW-1:0]         x_inc, x_dec, y_inc, y_dec, x_stp, y_stp;

    plr_pkg::mac_ctrl_t    mac_ctrl;
    logic signed [FW-1:0]  op_a;
    logic signed [DW-1:0]  op_b;
    logic [MW-1:0]         mag;

    function automatic logic [CW-1:0] to_cell(input logic [POS_W-1:0] p);
        logic [SW-1:0] v;
        v = ({1'b0, p} + SW'(HALF)) >> FRAC_BITS;
        if (v > SW'(GRID_SIZE - 1))
        begin
            v = SW'(GRID_SIZE - 1);
        end
        return v[CW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] node_diff(input logic [CW-1:0] k,
                                                       input logic [POS_W-1:0] a);
        logic [NW-1:0] node;
        node = {k, {FRAC_BITS{1'b0}}};
        return $signed(DW'(node)) - $signed(DW'(a));
    endfunction

    always_comb
    begin
        ddx     = $signed({1'b0, x2_reg}) - $signed({1'b0, x_reg});
        ddy     = $signed({1'b0, y2_reg}) - $signed({1'b0, y_reg});
        adx     = ddx[CW] ? CW'(-ddx) : ddx[CW-1:0];
        ady     = ddy[CW] ? CW'(-ddy) : ddy[CW-1:0];
        xmaj    = !(adx < ady);
        dmaj    = xmaj ? adx : ady;
        dmin    = xmaj ? ady : adx;
        two_min = $signed({1'b0, dmin, 1'b0});
        two_maj = $signed({1'b0, dmaj, 1'b0});
        e0      = two_min - $signed(EW'(dmaj));
        inc2    = two_min - two_maj;
    end

    assign out_free = !ovalid_reg || m_tready;
    assign emit     = out_free && ((state_reg == S_STEP) || (state_reg == S_DIAG));
    assign x_inc    = x_reg + 1'b1;
    assign x_dec    = x_reg - 1'b1;
    assign y_inc    = y_reg + 1'b1;
    assign y_dec    = y_reg - 1'b1;
    assign x_stp    = sxn_reg ? x_dec : x_inc;
    assign y_stp    = syn_reg ? y_dec : y_inc;

    // operand selection for the shared unit
    always_comb
    begin
        mac_ctrl = '0;
        op_a     = fdy_reg;
        op_b     = node_diff(x_reg, seg_reg.ax);
        unique case (state_reg)
            S_MA0:
            begin
                mac_ctrl.mul = 1'b1;
                op_b         = node_diff(ca_x_reg, seg_reg.ax);
            end
            S_MA1:
            begin
                mac_ctrl.mul  = 1'b1;
                mac_ctrl.load = 1'b1;
                op_a          = fdx_reg;
                op_b          = node_diff(ca_y_reg, seg_reg.ay);
            end
            S_MB0:
            begin
                mac_ctrl.mul = 1'b1;
            end
            S_MB1:
            begin
                mac_ctrl.mul  = 1'b1;
                mac_ctrl.load = 1'b1;
                op_a          = fdx_reg;
                op_b          = node_diff(y_reg, seg_reg.ay);
            end
            S_MA2, S_MB2:
            begin
                mac_ctrl.sub = 1'b1;
            end
            default:
            begin
                mac_ctrl = '0;
            end
        endcase
    end

    plr_mac #(
        .OB_W (DW)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (op_a),
        .op_b  (op_b),
        .mag   (mag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            seg_reg    <= '0;
            fdx_reg    <= '0;
            fdy_reg    <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            x2_reg     <= '0;
            y2_reg     <= '0;
            ca_x_reg   <= '0;
            ca_y_reg   <= '0;
            xmaj_reg   <= 1'b0;
            sxn_reg    <= 1'b0;
            syn_reg    <= 1'b0;
            e_reg      <= '0;
            inc1_reg   <= '0;
            inc2_reg   <= '0;
            cnt_reg    <= '0;
            a_mag_reg  <= '0;
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
            ox_reg     <= '0;
            oy_reg     <= '0;
        end
        else
        begin
            if (m_tready && !emit)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        seg_reg   <= seg;
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    x_reg     <= to_cell(seg_reg.ax);
                    y_reg     <= to_cell(seg_reg.ay);
                    x2_reg    <= to_cell(seg_reg.cx);
                    y2_reg    <= to_cell(seg_reg.cy);
                    fdx_reg   <= $signed({1'b0, seg_reg.cx}) - $signed({1'b0, seg_reg.ax});
                    fdy_reg   <= $signed({1'b0, seg_reg.cy}) - $signed({1'b0, seg_reg.ay});
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    sxn_reg   <= ddx[CW];
                    syn_reg   <= ddy[CW];
                    xmaj_reg  <= xmaj;
                    e_reg     <= e0;
                    inc1_reg  <= two_min;
                    inc2_reg  <= inc2;
                    cnt_reg   <= dmaj;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        ox_reg     <= x_reg;
                        oy_reg     <= y_reg;
                        olast_reg  <= (cnt_reg == '0);
                        if (cnt_reg == '0)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg - 1'b1;
                            if (xmaj_reg)
                            begin
                                x_reg <= x_stp;
                            end
                            else
                            begin
                                y_reg <= y_stp;
                            end
                            if (e_reg[EW-1])
                            begin
                                e_reg <= e_reg + inc1_reg;
                            end
                            else
                            begin
                                // corner candidate keeps the old major coordinate
                                ca_x_reg  <= xmaj_reg ? x_reg : x_stp;
                                ca_y_reg  <= xmaj_reg ? y_stp : y_reg;
                                state_reg <= S_MA0;
                            end
                        end
                    end
                end
                S_MA0:
                begin
                    state_reg <= S_MA1;
                end
                S_MA1:
                begin
                    state_reg <= S_MA2;
                end
                S_MA2:
                begin
                    state_reg <= S_MB0;
                end
                S_MB0:
                begin
                    a_mag_reg <= mag;
                    state_reg <= S_MB1;
                end
                S_MB1:
                begin
                    state_reg <= S_MB2;
                end
                S_MB2:
                begin
                    state_reg <= S_DIAG;
                end
                S_DIAG:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        olast_reg  <= 1'b0;
                        // ties go to the cell on the new major coordinate
                        if (a_mag_reg < mag)
                        begin
                            ox_reg <= ca_x_reg;
                            oy_reg <= ca_y_reg;
                        end
                        else
                        begin
                            ox_reg <= x_reg;
                            oy_reg <= y_reg;
                        end
                        if (xmaj_reg)
                        begin
                            y_reg <= y_stp;
                        end
                        else
                        begin
                            x_reg <= x_stp;
                        end
                        e_reg     <= e_reg + inc2_reg;
                        state_reg <= S_STEP;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = plr_pkg::OUT_TDATA_W'({OW'(oy_reg), OW'(ox_reg)});

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// testbench of the polyline rasterizer: vertex stream in, predicted cell stream checked out
`timescale 1ns / 1ps

module tb;

    localparam int POS_W       = plr_pkg::POS_W;
    localparam int CELL_W      = plr_pkg::CELL_W;
    localparam int IN_TDATA_W  = plr_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = plr_pkg::OUT_TDATA_W;

    localparam int GRID_SIZE = 32;
    localparam int FRAC_BITS = 10;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int POS_MAX   = (1 << POS_W) - 1;
    localparam longint NODE_STEP = longint'(1) << FRAC_BITS;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             start;
    } vertex_t;

    typedef struct packed {
        logic [CELL_W-1:0] x;
        logic [CELL_W-1:0] y;
        logic              last;
    } cell_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // pos_x, pos_y
    logic                   s_tuser = 1'b0; // curve_start
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // cell_x, cell_y
    logic                   m_tlast;        // segment_end

    vertex_t vertex_q[$];
    cell_t   cell_q[$];
    vertex_t on_bus;
    cell_t   want;

    // predictor state
    logic [POS_W-1:0] prev_x = '0;
    logic [POS_W-1:0] prev_y = '0;
    logic             have_prev = 1'b0;

    int n_queued = 0;
    int n_taken = 0;
    int errors = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int calm_left[2] = '{0, 0};

    always #6 clk = ~clk;

    polyline_four_connected_rasterizer #(
        .GRID_SIZE(GRID_SIZE),
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    // mostly short gaps, a few long ones, and now and then a run with none at all
    function automatic int pick_gap(input int side);
        int r;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm_left[side] = $urandom_range(20, 120);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic int cell_of(input logic [POS_W-1:0] p);
        int v;
        v = (int'(p) + (ONE >> 1)) >>> FRAC_BITS;
        if (v > GRID_SIZE - 1)
            v = GRID_SIZE - 1;
        return v;
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void push_cell(input int x, input int y, input logic last);
        cell_t c;
        c.x = x[CELL_W-1:0];
        c.y = y[CELL_W-1:0];
        c.last = last;
        cell_q = {cell_q, c};
    endfunction

    // bresenham walk with a corner cell on every diagonal step
    task automatic rasterize_vertex(input vertex_t v);
        longint ax, ay, fdx, fdy, nx0, nx1, ny0, ny1, a, b;
        int x, y, dx, dy, sx, sy, t, e, inc1, inc2;
        logic xmajor;
        if (v.start || !have_prev)
        begin
            prev_x = v.x;
            prev_y = v.y;
            have_prev = 1'b1;
        end
        else
        begin
            ax = longint'(prev_x);
            ay = longint'(prev_y);
            fdx = longint'(v.x) - ax;
            fdy = longint'(v.y) - ay;
            x = cell_of(prev_x);
            y = cell_of(prev_y);
            dx = cell_of(v.x) - x;
            dy = cell_of(v.y) - y;
            sx = 1;
            sy = 1;
            prev_x = v.x;
            prev_y = v.y;
            if (dx != 0 || dy != 0)
            begin
                if (dx < 0)
                begin
                    dx = -dx;
                    sx = -1;
                end
                else if (dx == 0)
                    sx = 0;
                if (dy < 0)
                begin
                    dy = -dy;
                    sy = -1;
                end
                xmajor = (dx >= dy);
                if (!xmajor)
                begin
                    t = dx;
                    dx = dy;
                    dy = t;
                end
                inc1 = dy + dy;
                e = inc1 - dx;
                inc2 = e - dx;
                for (int i = 0; i < dx; i++)
                begin
                    push_cell(x, y, 1'b0);
                    if (xmajor)
                        x += sx;
                    else
                        y += sy;
                    if (e < 0)
                        e += inc1;
                    else
                    begin
                        // corner cell: nearer node wins, ties to the second choice
                        if (xmajor)
                        begin
                            nx0 = longint'(x - sx) * NODE_STEP;
                            nx1 = longint'(x) * NODE_STEP;
                            ny0 = longint'(y) * NODE_STEP;
                            ny1 = longint'(y + sy) * NODE_STEP;
                            a = mag(fdy * (nx0 - ax) + fdx * (ay - ny1));
                            b = mag(fdy * (nx1 - ax) + fdx * (ay - ny0));
                            if (a < b)
                            begin
                                y += sy;
                                push_cell(x - sx, y, 1'b0);
                            end
                            else
                            begin
                                push_cell(x, y, 1'b0);
                                y += sy;
                            end
                        end
                        else
                        begin
                            ny0 = longint'(y - sy) * NODE_STEP;
                            ny1 = longint'(y) * NODE_STEP;
                            nx0 = longint'(x) * NODE_STEP;
                            nx1 = longint'(x + sx) * NODE_STEP;
                            a = mag(fdx * (ny0 - ay) + fdy * (ax - nx1));
                            b = mag(fdx * (ny1 - ay) + fdy * (ax - nx0));
                            if (a < b)
                            begin
                                x += sx;
                                push_cell(x, y - sy, 1'b0);
                            end
                            else
                            begin
                                push_cell(x, y, 1'b0);
                                x += sx;
                            end
                        end
                        e += inc2;
                    end
                end
            end
            push_cell(x, y, 1'b1);
        end
    endtask

    function automatic void add_vertex(input int x, input int y, input logic start);
        vertex_t v;
        v.x = x[POS_W-1:0];
        v.y = y[POS_W-1:0];
        v.start = start;
        vertex_q = {vertex_q, v};
        n_queued++;
    endfunction

    function automatic int clamp_pos(input int p);
        if (p < 0)
            return 0;
        if (p > POS_MAX)
            return POS_MAX;
        return p;
    endfunction

    function automatic int any_pos();
        return $urandom_range(0, POS_MAX);
    endfunction

    // mostly whole curves with random content, the rest lone starts and raw noise
    task automatic fill_random(input int target);
        int pick, len, cx, cy;
        while (n_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                add_vertex(any_pos(), any_pos(), 1'b1);
            else if (pick < 14)
                add_vertex(any_pos(), any_pos(), logic'($urandom_range(0, 1)));
            else
            begin
                cx = any_pos();
                cy = any_pos();
                add_vertex(cx, cy, 1'b1);
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 20)
                    begin
                        cx = any_pos();
                        cy = any_pos();
                    end
                    else if (pick < 35)
                    begin
                        // small jitter, usually the same cell
                        cx = clamp_pos(cx + int'($urandom_range(0, 200)) - 100);
                        cy = clamp_pos(cy + int'($urandom_range(0, 200)) - 100);
                    end
                    else
                    begin
                        cx = clamp_pos(cx + (int'($urandom_range(0, 16)) - 8) * ONE
                                       + int'($urandom_range(0, ONE - 1)) - ONE / 2);
                        cy = clamp_pos(cy + (int'($urandom_range(0, 16)) - 8) * ONE
                                       + int'($urandom_range(0, ONE - 1)) - ONE / 2);
                    end
                    add_vertex(cx, cy, 1'b0);
                end
            end
        end
    endtask

    // vertex source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            src_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                rasterize_vertex(on_bus);
                n_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    src_gap <= src_gap - 1;
                end
                else if (vertex_q.size() > 0)
                begin
                    on_bus = vertex_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(IN_TDATA_W - 2 * POS_W){1'b0}}, on_bus.y, on_bus.x};
                    s_tuser <= on_bus.start;
                    src_gap <= pick_gap(0);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // cell sink and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (cell_q.size() == 0)
                begin
                    $error("unexpected cell x=%0d y=%0d last=%0b",
                           m_tdata[CELL_W-1:0], m_tdata[2*CELL_W-1:CELL_W], m_tlast);
                    errors++;
                end
                else
                begin
                    want = cell_q.pop_front();
                    if (m_tdata[CELL_W-1:0] !== want.x)
                    begin
                        $error("cell_x: expected %0d, got %0d", want.x, m_tdata[CELL_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[2*CELL_W-1:CELL_W] !== want.y)
                    begin
                        $error("cell_y: expected %0d, got %0d", want.y,
                               m_tdata[2*CELL_W-1:CELL_W]);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("segment_end: expected %0b, got %0b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (sink_gap > 0)
            begin
                m_tready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                sink_gap <= pick_gap(1);
            end
        end
    end

    initial
    begin
        // no previous vertex yet, so this one only opens a curve
        add_vertex(5 * ONE, 5 * ONE, 1'b0);
        add_vertex(20 * ONE, 5 * ONE, 1'b0);
        add_vertex(20 * ONE + 300, 5 * ONE - 400, 1'b0);
        add_vertex(20 * ONE, 25 * ONE, 1'b0);
        add_vertex(0, 0, 1'b0);
        add_vertex(POS_MAX, POS_MAX, 1'b0);
        // exact diagonal, every corner is a tie
        add_vertex(3 * ONE, 3 * ONE, 1'b1);
        add_vertex(10 * ONE, 10 * ONE, 1'b0);
        // full anti-diagonal, most cells per segment
        add_vertex(31 * ONE, 0, 1'b1);
        add_vertex(0, 31 * ONE, 1'b0);
        // rounding on both sides of one half
        add_vertex(ONE / 2 - 1, ONE / 2, 1'b1);
        add_vertex(ONE / 2, ONE / 2 - 1, 1'b0);
        add_vertex(29 * ONE + 700, 2 * ONE + 100, 1'b0);
        add_vertex(ONE + 900, 30 * ONE + 50, 1'b0);
        add_vertex(POS_MAX, 0, 1'b1);
        add_vertex(POS_MAX, 0, 1'b1);
        add_vertex(0, POS_MAX, 1'b0);
        add_vertex(16 * ONE + ONE / 2, 7 * ONE + ONE / 2 - 1, 1'b0);
        add_vertex(8 * ONE, 12 * ONE, 1'b0);
        add_vertex(8 * ONE, 12 * ONE, 1'b0);
        fill_random(280);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (n_taken < n_queued || cell_q.size() > 0)
            @(posedge clk);
        repeat (250) @(posedge clk);

        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #48_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
